[hw/rtl/rc4_pkg.sv]
// Shared types and constants for the RC4 stream cipher core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 8;
   localparam int MEM_DEPTH  = 256;
   localparam int CNT_W      = 9;

   // request opcodes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // control from the sequencer to the permutation memory
   typedef struct packed {
      logic              clear;
      logic              re_a;
      logic [ADDR_W-1:0] addr_a;
      logic              re_b;
      logic [ADDR_W-1:0] addr_b;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
   } perm_req_type;

endpackage

[hw/rtl/rc4_perm_mem.sv]
// Permutation memory: two registered read ports, one write port.
// Per-entry valid bits make an unwritten entry read as its own address.
// Depends on rc4_pkg.
`timescale 1ns / 1ps

module rc4_perm_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  rc4_pkg::perm_req_type     perm_req,
   output logic [rc4_pkg::BYTE_W-1:0] rd_a,
   output logic [rc4_pkg::BYTE_W-1:0] rd_b
);
   import rc4_pkg::*;

   logic [BYTE_W-1:0]    mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [BYTE_W-1:0]    rd_a_ff;
   logic [BYTE_W-1:0]    rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset || perm_req.clear) begin
         valid_ff <= '0;
      end else if (perm_req.we) begin
         valid_ff[perm_req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (perm_req.we) begin
         mem[perm_req.waddr] <= perm_req.wdata;
      end
      // reads return the value before a same-cycle write
      if (perm_req.re_a) begin
         rd_a_ff <= valid_ff[perm_req.addr_a] ? mem[perm_req.addr_a] : perm_req.addr_a;
      end
      if (perm_req.re_b) begin
         rd_b_ff <= valid_ff[perm_req.addr_b] ? mem[perm_req.addr_b] : perm_req.addr_b;
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

[hw/rtl/rc4_key_mem.sv]
// Key store: 256 x 8, one write port, one registered read port.
// Depends on rc4_pkg.
`timescale 1ns / 1ps

module rc4_key_mem (
   input  logic                       clock,
   input  logic                       we,
   input  logic [rc4_pkg::ADDR_W-1:0] waddr,
   input  logic [rc4_pkg::BYTE_W-1:0] wdata,
   input  logic                       re,
   input  logic [rc4_pkg::ADDR_W-1:0] raddr,
   output logic [rc4_pkg::BYTE_W-1:0] rdata
);
   import rc4_pkg::*;

   logic [BYTE_W-1:0] mem [MEM_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/rc4_stream_cipher_core.sv]
// RC4 stream cipher core.
// req channel (valid/ready): req_op selects a key byte (0) or a data byte (1).
//   Key bytes fill a 256-byte key store; bytes past the 256th are dropped.
//   req_key_last on a key byte runs the key schedule: the permutation
//   returns to identity, 256 swap steps run over the key, indices clear.
//   req_message_start on a data byte clears both indices before the step.
// rsp channel (valid/ready): one rsp_out_byte per data byte, none per key byte.
// Steps: a key_last byte adds the key schedule, each swap step a
//   read-modify-write chain on the permutation memory (ST_KS_RD, ST_KS_J,
//   ST_KS_W1, ST_KS_W2). A data byte reads S[i] at acceptance, then
//   reads S[j], writes S[i] while reading S[S[i]+S[j]], writes S[j] and
//   registers rsp_valid. A new byte is taken only once the last is done.
// Requests are accepted only while the sequencer is idle. A pending response
//   does not block acceptance; a data byte waits in its final step only when
//   the previous response has still not been taken.
// Reset: permutation reads as identity, key count and indices clear.
// Depends on rc4_pkg, rc4_perm_mem, rc4_key_mem.
`timescale 1ns / 1ps

module rc4_stream_cipher_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [rc4_pkg::BYTE_W-1:0] req_value,
   input  logic                       req_key_last,
   input  logic                       req_message_start,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0] rsp_out_byte
);
   import rc4_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_W1,
      ST_KS_W2,
      ST_D_J,
      ST_D_W1,
      ST_D_W2
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] si_ff, si_in;
   logic [BYTE_W-1:0] sj_ff, sj_in;
   logic [BYTE_W-1:0] value_ff, value_in;
   logic              hit_i_ff, hit_i_in;
   logic              hit_j_ff, hit_j_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   perm_req_type      perm_req;
   logic [BYTE_W-1:0] perm_rd_a;
   logic [BYTE_W-1:0] perm_rd_b;

   logic              key_we;
   logic              key_re;
   logic [BYTE_W-1:0] key_rd;

   logic [ADDR_W-1:0] base_i;
   logic [ADDR_W-1:0] j_next;
   logic [ADDR_W-1:0] sum_t;
   logic [BYTE_W-1:0] ks;
   logic [CNT_W-1:0]  cnt_inc;

   rc4_perm_mem u_perm (
      .clock    (clock),
      .reset    (reset),
      .perm_req (perm_req),
      .rd_a     (perm_rd_a),
      .rd_b     (perm_rd_b)
   );

   rc4_key_mem u_key (
      .clock (clock),
      .we    (key_we),
      .waddr (cnt_ff[ADDR_W-1:0]),
      .wdata (req_value),
      .re    (key_re),
      .raddr (k_ff),
      .rdata (key_rd)
   );

   assign base_i  = req_message_start ? '0 : i_ff;
   assign cnt_inc = cnt_ff[CNT_W-1] ? cnt_ff : CNT_W'(cnt_ff + 1'b1);
   assign sum_t   = ADDR_W'(si_ff + perm_rd_a);
   // keystream with forwarding for the two entries swapped this step
   assign ks      = hit_j_ff ? si_ff : (hit_i_ff ? sj_ff : perm_rd_b);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      value_in     = value_ff;
      hit_i_in     = hit_i_ff;
      hit_j_in     = hit_j_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      perm_req     = '0;
      key_we       = 1'b0;
      key_re       = 1'b0;
      j_next       = '0;
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_KEY) begin
                  key_we = ~cnt_ff[CNT_W-1];
                  cnt_in = cnt_inc;
                  if (req_key_last) begin
                     len_in         = cnt_inc;
                     perm_req.clear = 1'b1;
                     i_in           = '0;
                     j_in           = '0;
                     k_in           = '0;
                     state_in       = ST_KS_RD;
                  end
               end else begin
                  i_in            = ADDR_W'(base_i + 1'b1);
                  j_in            = req_message_start ? '0 : j_ff;
                  perm_req.re_a   = 1'b1;
                  perm_req.addr_a = ADDR_W'(base_i + 1'b1);
                  value_in        = req_value;
                  state_in        = ST_D_J;
               end
            end
         end
         ST_KS_RD: begin
            perm_req.re_a   = 1'b1;
            perm_req.addr_a = i_ff;
            key_re          = 1'b1;
            state_in        = ST_KS_J;
         end
         ST_KS_J: begin
            j_next          = ADDR_W'(j_ff + perm_rd_a + key_rd);
            j_in            = j_next;
            si_in           = perm_rd_a;
            perm_req.re_a   = 1'b1;
            perm_req.addr_a = j_next;
            state_in        = ST_KS_W1;
         end
         ST_KS_W1: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = i_ff;
            perm_req.wdata = perm_rd_a;
            state_in       = ST_KS_W2;
         end
         ST_KS_W2: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            i_in           = ADDR_W'(i_ff + 1'b1);
            // key index wraps at the stored key length
            k_in = (CNT_W'({1'b0, k_ff} + 1'b1) == len_ff) ? '0 : ADDR_W'(k_ff + 1'b1);
            if (i_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               j_in     = '0;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD;
            end
         end
         ST_D_J: begin
            j_next          = ADDR_W'(j_ff + perm_rd_a);
            j_in            = j_next;
            si_in           = perm_rd_a;
            perm_req.re_a   = 1'b1;
            perm_req.addr_a = j_next;
            state_in        = ST_D_W1;
         end
         ST_D_W1: begin
            perm_req.we     = 1'b1;
            perm_req.waddr  = i_ff;
            perm_req.wdata  = perm_rd_a;
            perm_req.re_b   = 1'b1;
            perm_req.addr_b = sum_t;
            hit_i_in        = (sum_t == i_ff);
            hit_j_in        = (sum_t == j_ff);
            sj_in           = perm_rd_a;
            state_in        = ST_D_W2;
         end
         ST_D_W2: begin
            if (!rsp_valid_ff || rsp_ready) begin
               perm_req.we    = 1'b1;
               perm_req.waddr = j_ff;
               perm_req.wdata = si_ff;
               rsp_byte_in    = value_ff ^ ks;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      value_ff    <= value_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !perm_req.we)
      else $error("permutation written while idle");

   a_key_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MEM_DEPTH))
      else $error("key count above key store depth");

   a_sched_end_clear: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_KS_W2) && state_ff == ST_IDLE)
         |-> (i_ff == '0 && j_ff == '0 && cnt_ff == '0))
      else $error("indices or key count not cleared after key schedule");

   a_stall_holds_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_D_W2 && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_D_W2))
      else $error("data step finished over an untaken response");

endmodule

[tb/sv/tb_rc4_stream_cipher_core.sv]
// Self-checking testbench for rc4_stream_cipher_core: keyed and unkeyed streams checked
// byte by byte against an in-bench RC4 predictor, under random request and response idling.
// Depends on rc4_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_core;

   import rc4_pkg::*;

   localparam int WATCHDOG_LIMIT = 8000;
   localparam int RANDOM_PER_PHASE = 410;

   typedef struct {
      logic              op;
      logic [BYTE_W-1:0] value;
      logic              key_last;
      logic              message_start;
   } cipher_req_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = OP_KEY;
   logic [BYTE_W-1:0] req_value = '0;
   logic              req_key_last = 1'b0;
   logic              req_message_start = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;

   rc4_stream_cipher_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_key_last      (req_key_last),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [BYTE_W-1:0] sbox [MEM_DEPTH];
   logic [BYTE_W-1:0] key_bytes [MEM_DEPTH];
   logic [CNT_W-1:0]  key_count = '0;
   logic [ADDR_W-1:0] gen_i = '0;
   logic [ADDR_W-1:0] gen_j = '0;

   cipher_req_type    pending_reqs[$];
   logic [BYTE_W-1:0] expected_bytes[$];
   cipher_req_type    next_req;
   logic              req_taken = 1'b0;
   int                sender_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                error_count = 0;
   int                idle_cycles = 0;
   int                stim_items = 0;

   initial begin
      for (int n = 0; n < MEM_DEPTH; n++) sbox[ADDR_W'(n)] = n[BYTE_W-1:0];
   end

   task automatic rc4_predict(input cipher_req_type r);
      logic [BYTE_W-1:0] tmp;
      logic [BYTE_W-1:0] sj;
      int                len;
      if (r.op == OP_KEY) begin
         if (key_count < MEM_DEPTH) begin
            key_bytes[key_count[ADDR_W-1:0]] = r.value;
            key_count = key_count + 1'b1;
         end
         if (r.key_last) begin
            len = (key_count == 0 || key_count > MEM_DEPTH) ? MEM_DEPTH : int'(key_count);
            for (int n = 0; n < MEM_DEPTH; n++) sbox[ADDR_W'(n)] = n[BYTE_W-1:0];
            sj = '0;
            for (int n = 0; n < MEM_DEPTH; n++) begin
               sj = sj + sbox[ADDR_W'(n)] + key_bytes[ADDR_W'(n % len)];
               tmp = sbox[ADDR_W'(n)];
               sbox[ADDR_W'(n)] = sbox[sj];
               sbox[sj] = tmp;
            end
            gen_i = '0;
            gen_j = '0;
            key_count = '0;
         end
      end else begin
         if (r.message_start) begin
            gen_i = '0;
            gen_j = '0;
         end
         gen_i = gen_i + 1'b1;
         gen_j = gen_j + sbox[gen_i];
         tmp = sbox[gen_i];
         sbox[gen_i] = sbox[gen_j];
         sbox[gen_j] = tmp;
         tmp = sbox[gen_i] + sbox[gen_j];
         expected_bytes.push_back(r.value ^ sbox[tmp]);
      end
   endtask

   task automatic push_req(input logic op, input logic [BYTE_W-1:0] value,
                           input logic key_last, input logic message_start);
      cipher_req_type r;
      r.op = op;
      r.value = value;
      r.key_last = key_last;
      r.message_start = message_start;
      pending_reqs.push_back(r);
   endtask

   // key bytes past the 256th are dropped by the core, so they are not counted
   task automatic push_key(input int len, input logic mark_last);
      for (int k = 0; k < len; k++) begin
         push_req(OP_KEY, BYTE_W'($urandom_range(0, 255)), mark_last && (k == len - 1),
                  1'($urandom_range(0, 1)));
         if (k < MEM_DEPTH) stim_items++;
      end
   endtask

   task automatic push_message(input int len, input logic restart);
      for (int k = 0; k < len; k++) begin
         push_req(OP_DATA, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                  (k == 0) ? restart : ($urandom_range(0, 49) == 0));
         stim_items++;
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   function automatic int pick_key_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 84) return $urandom_range(1, 16);
      if (r < 92) return $urandom_range(17, 255);
      if (r < 96) return MEM_DEPTH;
      return $urandom_range(257, 300);
   endfunction

   // driver: new request or hold at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_op <= next_req.op;
            req_value <= next_req.value;
            req_key_last <= next_req.key_last;
            req_message_start <= next_req.message_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // monitor, predictor update and watchdog
   always @(posedge clock) begin : monitor
      logic [BYTE_W-1:0] want;
      cipher_req_type    seen;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response: out_byte=%02h", rsp_out_byte);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("out_byte mismatch: expected %02h, actual %02h",
                              want, rsp_out_byte);
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.op = req_op;
            seen.value = req_value;
            seen.key_last = req_key_last;
            seen.message_start = req_message_start;
            rc4_predict(seen);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rc4_stream_cipher_core: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int r;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // data before any key runs on the identity permutation
      push_req(OP_DATA, 8'h00, 1'b0, 1'b1);
      push_req(OP_DATA, 8'hFF, 1'b0, 1'b0);
      push_req(OP_DATA, 8'hA5, 1'b1, 1'b0);   // key_last on data is ignored
      push_req(OP_DATA, 8'h5A, 1'b0, 1'b1);
      // message_start on a key byte is ignored
      push_req(OP_KEY, 8'h00, 1'b0, 1'b1);
      push_req(OP_KEY, 8'hFF, 1'b0, 1'b0);
      push_req(OP_KEY, 8'h80, 1'b1, 1'b0);
      push_req(OP_DATA, 8'h00, 1'b0, 1'b1);
      push_req(OP_DATA, 8'hFF, 1'b0, 1'b0);
      push_req(OP_DATA, 8'h3C, 1'b0, 1'b0);
      push_req(OP_DATA, 8'h00, 1'b0, 1'b1);   // new message, same permutation
      push_req(OP_DATA, 8'hFF, 1'b0, 1'b0);
      // one-byte keys at the value extremes
      push_req(OP_KEY, 8'hFF, 1'b1, 1'b0);
      push_req(OP_DATA, 8'h00, 1'b0, 1'b1);
      push_req(OP_DATA, 8'h00, 1'b0, 1'b0);
      push_req(OP_DATA, 8'h00, 1'b0, 1'b0);
      push_req(OP_KEY, 8'h00, 1'b1, 1'b0);
      push_req(OP_DATA, 8'hFF, 1'b0, 1'b1);
      push_req(OP_DATA, 8'h00, 1'b0, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin sender_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         stim_items = 0;
         // overlong key in one phase, exactly full key store in another
         if (phase == 0) begin
            push_key(260, 1'b1);
            push_message($urandom_range(1, 48), 1'b1);
         end else if (phase == 1) begin
            push_key(MEM_DEPTH, 1'b1);
            push_message($urandom_range(1, 48), 1'b1);
         end
         while (stim_items < RANDOM_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               push_key(pick_key_len(), 1'b1);
               push_message($urandom_range(1, 48), 1'b1);
            end else if (r < 85) begin
               push_message($urandom_range(1, 48), 1'b1);
            end else if (r < 95) begin
               repeat ($urandom_range(1, 6)) begin
                  push_req(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  stim_items++;
               end
            end else if (r < 98) begin
               push_key($urandom_range(1, 20), 1'b0);   // partial key, extended later
            end else begin
               push_message($urandom_range(1, 12), 1'b0);
            end
            // keep the queue short so that idling settings apply to this phase
            while (pending_reqs.size() > 64) @(posedge clock);
         end
         wait_drained();
      end

      repeat (32) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0)
         $display("tb_rc4_stream_cipher_core: PASS");
      else
         $display("tb_rc4_stream_cipher_core: FAIL");
      $finish;
   end

endmodule
